>>> rtl/core/bicycle_model_dead_reckoning_assert.svh
// Assertion macros used by the checker file of the odometry block.
`ifndef BICYCLE_MODEL_DEAD_RECKONING_ASSERT_SVH
`define BICYCLE_MODEL_DEAD_RECKONING_ASSERT_SVH

// Checked on every rising edge outside reset.
`define BMDR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bmdr assertion failed");

// Checked on every rising edge, reset included.
`define BMDR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bmdr assertion failed");

`endif

>>> rtl/core/bmdr_pkg.sv
// ----------------------------------------------------------------------------
// bmdr_pkg
// Types, constants and the CORDIC arctangent table of the odometry block.
// ----------------------------------------------------------------------------
`default_nettype none

package bmdr_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int HEADING_BITS_DEF = 32;

  localparam int CORDIC_W = 34;
  localparam int MUL_BITS = 34;
  localparam int PROD_W   = 64;

  localparam logic signed [CORDIC_W-1:0] CORDIC_ONE_K  = 34'sd652032874;
  localparam logic signed [PROD_W-1:0]   STEER_TO_BAM  = 64'sd2734261102;
  localparam logic signed [MUL_BITS-1:0] YAW_DT_TO_BAM = 34'sd174991;
  localparam logic signed [MUL_BITS-1:0] MM_PER_M      = 34'sd1000;
  localparam logic [PROD_W-1:0]          POS_DEN       = 64'd4194304000;

  localparam logic [15:0] INV_WHEELBASE_RST = 16'd15938;
  localparam logic [19:0] MAX_STEP_RST      = 20'd500000;

  typedef enum logic {
    REG_INV_WHEELBASE = 1'b0,
    REG_MAX_STEP_US   = 1'b1
  } reg_index_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_STEER_MUL,
    S_STEER_COR,
    S_VW_MUL,
    S_NUM_MUL,
    S_DEN_MUL,
    S_YAW_DIV,
    S_HD_MUL1,
    S_HD_MUL2,
    S_POS_COR,
    S_P_MUL,
    S_X_MUL,
    S_X_DIV,
    S_Y_MUL,
    S_Y_DIV,
    S_Q_COR,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                       start;
    logic signed [PROD_W-1:0]   a;
    logic signed [MUL_BITS-1:0] b;
  } mul_req_t;

  function automatic logic [31:0] atan_ent(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/bmdr_mul.sv
// ----------------------------------------------------------------------------
// bmdr_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, shift and add.
// ----------------------------------------------------------------------------
`default_nettype none

module bmdr_mul
  import bmdr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire mul_req_t                 req,
  output logic                          done,
  output logic signed [PROD_W-1:0]      prod
);

  localparam int CW = $clog2(MUL_BITS);
  localparam logic [CW-1:0] LAST = CW'(MUL_BITS - 1);

  logic                       busy;
  logic [CW-1:0]              cnt;
  logic signed [PROD_W-1:0]   a_sh;
  logic [MUL_BITS-1:0]        b_sh;
  logic signed [PROD_W-1:0]   acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // The top bit of the multiplier carries negative weight.
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_sh <= req.a;
      b_sh <= req.b;
      acc  <= '0;
      cnt  <= '0;
    end else if (busy) begin
      if (b_sh[0]) begin
        acc <= (cnt == LAST) ? acc - a_sh : acc + a_sh;
      end
      a_sh <= a_sh <<< 1;
      b_sh <= b_sh >> 1;
      cnt  <= cnt + 1'b1;
    end
  end

  assign prod = acc;

endmodule

`default_nettype wire

>>> rtl/core/bmdr_div.sv
// ----------------------------------------------------------------------------
// bmdr_div
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bmdr_div
  import bmdr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] num,
  input  wire logic [PROD_W-1:0] den,
  output logic                   done,
  output logic [PROD_W-1:0]      quo
);

  localparam int CW = $clog2(PROD_W);
  localparam logic [CW-1:0] LAST = CW'(PROD_W - 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] dvs;
  logic [PROD_W:0]   trial;
  logic              fits;

  assign trial = {rem, quo[PROD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
      cnt <= '0;
    end else if (busy) begin
      rem <= fits ? PROD_W'(trial - {1'b0, dvs}) : PROD_W'(trial);
      quo <= {quo[PROD_W-2:0], fits};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bmdr_cordic.sv
// ----------------------------------------------------------------------------
// bmdr_cordic
// Iterative rotation-mode CORDIC, one step per cycle, cos and sin in Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module bmdr_cordic
  import bmdr_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
)
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [31:0]               ang,
  output logic                           done,
  output logic signed [CORDIC_W-1:0]     cos_q,
  output logic signed [CORDIC_W-1:0]     sin_q
);

  localparam int CW = $clog2(STEPS);
  localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

  logic                       busy;
  logic                       flip;
  logic                       flip_in;
  logic [31:0]                ang_f;
  logic [CW-1:0]              cnt;
  logic signed [CORDIC_W-1:0] x;
  logic signed [CORDIC_W-1:0] y;
  logic signed [CORDIC_W-1:0] z;
  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;
  logic signed [CORDIC_W-1:0] at;

  // Angles beyond a quarter circle are turned by a half circle first.
  assign flip_in = ang[31] ^ ang[30];
  assign ang_f   = flip_in ? {~ang[31], ang[30:0]} : ang;

  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign at = CORDIC_W'(atan_ent(5'(cnt)));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      flip <= flip_in;
      x    <= CORDIC_ONE_K;
      y    <= '0;
      z    <= CORDIC_W'($signed(ang_f));
      cnt  <= '0;
    end else if (busy) begin
      if (!z[CORDIC_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
      cnt <= cnt + 1'b1;
    end
  end

  assign cos_q = flip ? -x : x;
  assign sin_q = flip ? -y : y;

endmodule

`default_nettype wire

>>> rtl/core/bicycle_model_dead_reckoning.sv
// ----------------------------------------------------------------------------
// bicycle_model_dead_reckoning
// Kinematic bicycle odometry: yaw rate, heading, position and quaternion.
// ----------------------------------------------------------------------------
// A tick beat (speed_mm_s, steer_angle, elapsed_us) is taken when tick_valid
// is high and tick_stall is low. tick_stall is high while a tick is in work.
// A tick with zero elapsed time or more than max_step_us yields no pose beat
// and leaves the block free in the next cycle.
// Each accepted tick runs on one sequencer that shares a bit-serial
// multiplier (nine uses), an iterative CORDIC (three uses) and a bit-serial
// divider (three uses); most of the time per tick goes to the multiplier.
// The pose beat waits in an output register while pose_stall is high; the
// sequencer holds the next tick only until that register frees.
// Configuration writes (cfg_write_en, cfg_index, cfg_data) take effect at
// once; the user must make them while no tick is in work (not enforced).
// Synchronous reset clears heading, position and the pose valid flag and
// restores the reset register values.
`default_nettype none

module bicycle_model_dead_reckoning
  import bmdr_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int HEADING_BITS = HEADING_BITS_DEF
)
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_en,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [19:0]        cfg_data,
  input  wire logic               tick_valid,
  output logic                    tick_stall,
  input  wire logic signed [15:0] speed_mm_s,
  input  wire logic signed [15:0] steer_angle,
  input  wire logic [19:0]        elapsed_us,
  output logic                    pose_valid,
  input  wire logic               pose_stall,
  output logic signed [31:0]      pos_x_um,
  output logic signed [31:0]      pos_y_um,
  output logic [15:0]             heading_bam,
  output logic signed [15:0]      speed_out,
  output logic signed [23:0]      turn_rate,
  output logic signed [15:0]      quat_z,
  output logic signed [15:0]      quat_w
);

  localparam int HD_SHIFT = 20 + 32 - HEADING_BITS;
  localparam logic signed [PROD_W-1:0] HD_RND = 64'sd1 <<< (HD_SHIFT - 1);

  state_t state;
  state_t state_next;
  logic   launched;
  logic   launched_next;
  logic   op_done;
  logic   dt_ok;
  logic   pose_free;

  mul_req_t                   mul_req;
  logic                       mul_done;
  logic signed [PROD_W-1:0]   mul_p;
  logic                       cor_start;
  logic [31:0]                cor_ang;
  logic                       cor_done;
  logic signed [CORDIC_W-1:0] cor_c;
  logic signed [CORDIC_W-1:0] cor_s;
  logic                       div_start;
  logic [PROD_W-1:0]          div_num;
  logic [PROD_W-1:0]          div_den;
  logic                       div_done;
  logic [PROD_W-1:0]          div_q;

  logic [15:0]                inv_wheelbase;
  logic [19:0]                max_step_us;
  logic [HEADING_BITS-1:0]    heading;
  logic signed [31:0]         pos_x;
  logic signed [31:0]         pos_y;

  logic signed [15:0]         v;
  logic signed [15:0]         st;
  logic [19:0]                dt;
  logic [31:0]                ang;
  logic signed [CORDIC_W-1:0] sc;
  logic signed [CORDIC_W-1:0] ss;
  logic signed [CORDIC_W-1:0] hc;
  logic signed [CORDIC_W-1:0] hs;
  logic signed [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]          mag;
  logic                       neg;
  logic [PROD_W-1:0]          den;
  logic signed [23:0]         yaw;
  logic signed [15:0]         qz;
  logic signed [15:0]         qw;

  logic [31:0]                h32;
  logic signed [PROD_W-1:0]   delta;
  logic signed [CORDIC_W-1:0] cx;
  logic signed [CORDIC_W-1:0] cy;
  logic signed [39:0]         pos_step;
  logic signed [31:0]         pos_cur;
  logic signed [40:0]         pos_sum;
  logic signed [31:0]         pos_sat;
  logic signed [23:0]         yaw_sat;

  function automatic logic signed [15:0] quat_round(input logic signed [CORDIC_W-1:0] q);
    logic signed [CORDIC_W-1:0] r;
    logic signed [15:0]         o;
    r = (q + 34'sd32768) >>> 16;
    if (r > 34'sd16384) begin
      o = 16'sd16384;
    end else if (r < -34'sd16384) begin
      o = -16'sd16384;
    end else begin
      o = 16'(r);
    end
    return o;
  endfunction

  bmdr_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .prod (mul_p)
  );

  bmdr_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .ang   (cor_ang),
    .done  (cor_done),
    .cos_q (cor_c),
    .sin_q (cor_s)
  );

  bmdr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign tick_stall = (state != S_IDLE);
  assign dt_ok      = (elapsed_us != 20'd0) && (elapsed_us <= max_step_us);
  assign pose_free  = !pose_valid || !pose_stall;

  assign h32   = 32'(heading) << (32 - HEADING_BITS);
  assign delta = (mul_p + HD_RND) >>> HD_SHIFT;
  assign cx    = (hc + 34'sd128) >>> 8;
  assign cy    = (hs + 34'sd128) >>> 8;

  assign pos_step = neg ? -$signed(div_q[39:0]) : $signed(div_q[39:0]);
  assign pos_cur  = (state == S_Y_DIV) ? pos_y : pos_x;
  assign pos_sum  = 41'(pos_cur) + 41'(pos_step);

  always_comb begin
    if (pos_sum > 41'sd2147483647) begin
      pos_sat = 32'sh7FFFFFFF;
    end else if (pos_sum < -41'sd2147483648) begin
      pos_sat = 32'sh80000000;
    end else begin
      pos_sat = 32'(pos_sum);
    end
  end

  always_comb begin
    if (!neg) begin
      yaw_sat = (div_q > 64'd8388607) ? 24'sh7FFFFF : $signed(div_q[23:0]);
    end else begin
      yaw_sat = (div_q > 64'd8388608) ? 24'sh800000 : -$signed(div_q[23:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launched <= 1'b0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
    end
  end

  always_comb begin
    state_next    = state;
    op_done       = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = '0;
    mul_req.b     = '0;
    cor_start     = 1'b0;
    cor_ang       = '0;
    div_start     = 1'b0;
    div_num       = '0;
    div_den       = '0;
    unique case (state)
      S_IDLE: begin
        if (tick_valid && dt_ok) begin
          state_next = S_STEER_MUL;
        end
      end
      S_STEER_MUL: begin
        mul_req.start = !launched;
        mul_req.a     = STEER_TO_BAM;
        mul_req.b     = MUL_BITS'(st);
        op_done       = mul_done;
        if (mul_done) state_next = S_STEER_COR;
      end
      S_STEER_COR: begin
        cor_start = !launched;
        cor_ang   = ang;
        op_done   = cor_done;
        if (cor_done) state_next = S_VW_MUL;
      end
      S_VW_MUL: begin
        mul_req.start = !launched;
        mul_req.a     = PROD_W'(v);
        mul_req.b     = MUL_BITS'(inv_wheelbase);
        op_done       = mul_done;
        if (mul_done) state_next = S_NUM_MUL;
      end
      S_NUM_MUL: begin
        mul_req.start = !launched;
        mul_req.a     = prod;
        mul_req.b     = ss;
        op_done       = mul_done;
        if (mul_done) state_next = S_DEN_MUL;
      end
      S_DEN_MUL: begin
        mul_req.start = !launched;
        mul_req.a     = PROD_W'(sc);
        mul_req.b     = MM_PER_M;
        op_done       = mul_done;
        if (mul_done) state_next = S_YAW_DIV;
      end
      S_YAW_DIV: begin
        div_start = !launched;
        div_num   = mag + (den >> 1);
        div_den   = den;
        op_done   = div_done;
        if (div_done) state_next = S_HD_MUL1;
      end
      S_HD_MUL1: begin
        mul_req.start = !launched;
        mul_req.a     = PROD_W'(yaw);
        mul_req.b     = MUL_BITS'(dt);
        op_done       = mul_done;
        if (mul_done) state_next = S_HD_MUL2;
      end
      S_HD_MUL2: begin
        mul_req.start = !launched;
        mul_req.a     = prod;
        mul_req.b     = YAW_DT_TO_BAM;
        op_done       = mul_done;
        if (mul_done) state_next = S_POS_COR;
      end
      S_POS_COR: begin
        cor_start = !launched;
        cor_ang   = h32;
        op_done   = cor_done;
        if (cor_done) state_next = S_P_MUL;
      end
      S_P_MUL: begin
        mul_req.start = !launched;
        mul_req.a     = PROD_W'(v);
        mul_req.b     = MUL_BITS'(dt);
        op_done       = mul_done;
        if (mul_done) state_next = S_X_MUL;
      end
      S_X_MUL: begin
        mul_req.start = !launched;
        mul_req.a     = prod;
        mul_req.b     = cx;
        op_done       = mul_done;
        if (mul_done) state_next = S_X_DIV;
      end
      S_X_DIV: begin
        div_start = !launched;
        div_num   = mag + (POS_DEN >> 1);
        div_den   = POS_DEN;
        op_done   = div_done;
        if (div_done) state_next = S_Y_MUL;
      end
      S_Y_MUL: begin
        mul_req.start = !launched;
        mul_req.a     = prod;
        mul_req.b     = cy;
        op_done       = mul_done;
        if (mul_done) state_next = S_Y_DIV;
      end
      S_Y_DIV: begin
        div_start = !launched;
        div_num   = mag + (POS_DEN >> 1);
        div_den   = POS_DEN;
        op_done   = div_done;
        if (div_done) state_next = S_Q_COR;
      end
      S_Q_COR: begin
        cor_start = !launched;
        cor_ang   = {h32[31], h32[31:1]};
        op_done   = cor_done;
        if (cor_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (pose_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (op_done) begin
      launched_next = 1'b0;
    end else if (mul_req.start || cor_start || div_start) begin
      launched_next = 1'b1;
    end else begin
      launched_next = launched;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_wheelbase <= INV_WHEELBASE_RST;
      max_step_us   <= MAX_STEP_RST;
      heading       <= '0;
      pos_x         <= '0;
      pos_y         <= '0;
      pose_valid    <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        if (cfg_index == REG_INV_WHEELBASE) begin
          inv_wheelbase <= cfg_data[15:0];
        end else begin
          max_step_us <= cfg_data;
        end
      end
      if (state == S_HD_MUL2 && mul_done) begin
        heading <= heading + delta[HEADING_BITS-1:0];
      end
      if (state == S_X_DIV && div_done) begin
        pos_x <= pos_sat;
      end
      if (state == S_Y_DIV && div_done) begin
        pos_y <= pos_sat;
      end
      if (state == S_OUT && pose_free) begin
        pose_valid <= 1'b1;
      end else if (!pose_stall) begin
        pose_valid <= 1'b0;
      end
    end
  end

  // The speed-time product stays in prod for both axes, and the yaw
  // numerator magnitude survives the denominator multiply.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && tick_valid) begin
      v  <= speed_mm_s;
      dt <= elapsed_us;
      if (steer_angle > 16'sd16384) begin
        st <= 16'sd16384;
      end else if (steer_angle < -16'sd16384) begin
        st <= -16'sd16384;
      end else begin
        st <= steer_angle;
      end
    end
    if (mul_done) begin
      if (state != S_X_MUL) begin
        prod <= mul_p;
      end
      if (state != S_DEN_MUL) begin
        mag <= mul_p[PROD_W-1] ? PROD_W'(-mul_p) : PROD_W'(mul_p);
        neg <= mul_p[PROD_W-1];
      end
      if (state == S_STEER_MUL) begin
        ang <= 32'((mul_p + 64'sd32768) >>> 16);
      end
      if (state == S_DEN_MUL) begin
        den <= PROD_W'(mul_p);
      end
    end
    if (state == S_STEER_COR && cor_done) begin
      sc <= (cor_c < 34'sd1) ? 34'sd1 : cor_c;
      ss <= cor_s;
    end
    if (state == S_YAW_DIV && div_done) begin
      yaw <= yaw_sat;
    end
    if (state == S_POS_COR && cor_done) begin
      hc <= cor_c;
      hs <= cor_s;
    end
    if (state == S_Q_COR && cor_done) begin
      qz <= quat_round(cor_s);
      qw <= quat_round(cor_c);
    end
    if (state == S_OUT && pose_free) begin
      pos_x_um    <= pos_x;
      pos_y_um    <= pos_y;
      heading_bam <= h32[31:16];
      speed_out   <= v;
      turn_rate   <= yaw;
      quat_z      <= qz;
      quat_w      <= qw;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bmdr_checker.sv
// ----------------------------------------------------------------------------
// bmdr_checker
// Port-level checks of the odometry block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bicycle_model_dead_reckoning_assert.svh"

module bmdr_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               tick_valid,
  input wire logic               tick_stall,
  input wire logic [19:0]        elapsed_us,
  input wire logic               pose_valid,
  input wire logic               pose_stall,
  input wire logic signed [31:0] pos_x_um
);

  // Reset leaves no pose beat pending.
  `BMDR_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !pose_valid)

  // A tick with zero elapsed time leaves the block free at once.
  `BMDR_ASSERT(a_zero_tick_free, clk, rst, tick_valid && !tick_stall && elapsed_us == 20'd0 |=> !tick_stall)

  // A pose beat only appears at the end of a tick in work.
  `BMDR_ASSERT(a_pose_after_work, clk, rst, $rose(pose_valid) |-> $past(tick_stall))

  // A stalled pose beat holds.
  `BMDR_ASSERT(a_pose_hold, clk, rst, pose_valid && pose_stall |=> pose_valid && $stable(pos_x_um))

endmodule

bind bicycle_model_dead_reckoning bmdr_checker u_bmdr_checker (.*);

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Bicycle-model odometry testbench
// Sends speed, steering and elapsed-time ticks through the odometry block under
// random gaps and output stalls. A built-in fixed-point predictor works out the
// pose beat of each accepted tick, and every beat that arrives is checked field
// by field against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bmdr_pkg::*;

  localparam int LIMIT = 1000000;
  localparam int DRAIN_WAIT = 700;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [15:0] speed;
    logic signed [15:0] steer;
    logic [19:0]        dt;
  } tick_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        heading;
    logic signed [15:0] speed;
    logic signed [23:0] yaw;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } pose_t;

  localparam logic [31:0] ATAN_BAM [16] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [0:0] cfg_index = REG_INV_WHEELBASE;
  logic [19:0] cfg_data = '0;
  logic tick_valid = 1'b0;
  logic tick_stall;
  logic signed [15:0] speed_mm_s = '0;
  logic signed [15:0] steer_angle = '0;
  logic [19:0] elapsed_us = '0;
  logic pose_valid;
  logic pose_stall = 1'b0;
  logic signed [31:0] pos_x_um;
  logic signed [31:0] pos_y_um;
  logic [15:0] heading_bam;
  logic signed [15:0] speed_out;
  logic signed [23:0] turn_rate;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  tick_t tick_q[$];
  pose_t pose_q[$];
  int errors = 0;
  int cycles = 0;
  int hold_len = 0;
  bit no_idle = 1'b0;

  logic [15:0] inv_wb = INV_WHEELBASE_RST;
  logic [19:0] max_dt = MAX_STEP_RST;
  logic [31:0] heading_acc = '0;
  longint x_acc = 0;
  longint y_acc = 0;

  bicycle_model_dead_reckoning u_top (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .tick_valid(tick_valid), .tick_stall(tick_stall),
    .speed_mm_s(speed_mm_s), .steer_angle(steer_angle), .elapsed_us(elapsed_us),
    .pose_valid(pose_valid), .pose_stall(pose_stall),
    .pos_x_um(pos_x_um), .pos_y_um(pos_y_um), .heading_bam(heading_bam),
    .speed_out(speed_out), .turn_rate(turn_rate), .quat_z(quat_z), .quat_w(quat_w));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint round_div(input longint num, input longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint limit(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
    logic flip;
    longint x, y, z, dx, dy;
    flip = ang[31] ^ ang[30];
    if (flip) ang = ang + 32'h80000000;
    x = longint'(CORDIC_ONE_K);
    y = 0;
    z = longint'($signed(ang));
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_BAM[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_BAM[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Sets ok to 0 when the tick is rejected and leaves the accumulated pose untouched.
  task automatic predict_pose(input tick_t t, output bit ok, output pose_t p);
    longint v, st, dt, sc, ss, hc, hs, qc, qs, yaw, delta, vdt;
    logic [63:0] steer_bam;
    logic [31:0] half;
    v = longint'(t.speed);
    st = limit(longint'(t.steer), -16384, 16384);
    dt = longint'(t.dt);
    ok = !(dt == 0 || dt > longint'(max_dt));
    p = '{default: '0};
    if (ok) begin
      steer_bam = (st * 64'sd2734261102 + 32768) >>> 16;
      rotate(steer_bam[31:0], sc, ss);
      if (sc < 1) sc = 1;
      yaw = limit(round_div(v * longint'(inv_wb) * ss, sc * 1000), -8388608, 8388607);
      delta = (yaw * dt * 174991 + (64'sd1 <<< 19)) >>> 20;
      heading_acc = heading_acc + delta[31:0];
      rotate(heading_acc, hc, hs);
      vdt = v * dt;
      x_acc = limit(x_acc + round_div(vdt * ((hc + 128) >>> 8), 64'sd4194304000),
                    POS_MIN, POS_MAX);
      y_acc = limit(y_acc + round_div(vdt * ((hs + 128) >>> 8), 64'sd4194304000),
                    POS_MIN, POS_MAX);
      half = {heading_acc[31], heading_acc[31:1]};
      rotate(half, qc, qs);
      p.x = x_acc[31:0];
      p.y = y_acc[31:0];
      p.heading = heading_acc[31:16];
      p.speed = t.speed;
      p.yaw = yaw[23:0];
      p.qz = 16'(limit((qs + 32768) >>> 16, -16384, 16384));
      p.qw = 16'(limit((qc + 32768) >>> 16, -16384, 16384));
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic add_tick(input int speed, input int steer, input int dt);
    tick_t t;
    t.speed = speed[15:0];
    t.steer = steer[15:0];
    t.dt = dt[19:0];
    tick_q.push_back(t);
  endtask

  task automatic add_random(input int n);
    int speed, steer, dt;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0: speed = 32767;
        1: speed = -32768;
        default: speed = $signed($urandom_range(65535) - 32768);
      endcase
      if ($urandom_range(9) == 0) steer = $urandom_range(65535) - 32768;
      else steer = $urandom_range(32768) - 16384;
      case ($urandom_range(9))
        0: dt = 0;
        1: dt = (max_dt == 20'hFFFFF) ? 0 : $urandom_range(20'hFFFFF, int'(max_dt) + 1);
        default: dt = (max_dt == 0) ? 0 : $urandom_range(int'(max_dt), 1);
      endcase
      add_tick(speed, steer, dt);
    end
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || pose_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input int value);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[19:0];
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == REG_INV_WHEELBASE) inv_wb = value[15:0];
    else max_dt = value[19:0];
  endtask

  always @(posedge clk) begin
    tick_t t;
    pose_t p;
    bit ok;
    if (rst) begin
      tick_valid <= 1'b0;
    end else begin
      if (tick_valid && !tick_stall) begin
        t = tick_q.pop_front();
        predict_pose(t, ok, p);
        if (ok) pose_q.push_back(p);
      end
      if (!(tick_valid && tick_stall)) begin
        if (tick_q.size() != 0 && (no_idle || $urandom_range(99) >= 33)) begin
          tick_valid <= 1'b1;
          speed_mm_s <= tick_q[0].speed;
          steer_angle <= tick_q[0].steer;
          elapsed_us <= tick_q[0].dt;
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    pose_t p;
    if (!rst && pose_valid && !pose_stall) begin
      if (pose_q.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        p = pose_q.pop_front();
        if (pos_x_um != p.x) report("pos_x_um", pos_x_um, p.x);
        if (pos_y_um != p.y) report("pos_y_um", pos_y_um, p.y);
        if (heading_bam != p.heading) report("heading_bam", heading_bam, p.heading);
        if (speed_out != p.speed) report("speed_out", speed_out, p.speed);
        if (turn_rate != p.yaw) report("turn_rate", turn_rate, p.yaw);
        if (quat_z != p.qz) report("quat_z", quat_z, p.qz);
        if (quat_w != p.qw) report("quat_w", quat_w, p.qw);
      end
    end
    if (hold_len > 0) begin
      hold_len <= hold_len - 1;
      pose_stall <= 1'b1;
    end else begin
      pose_stall <= !no_idle && ($urandom_range(99) < 33);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("bicycle_model_dead_reckoning test failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    add_tick(0, 0, 1);
    add_tick(32767, 16384, 1000);
    add_tick(-32768, -16384, 1000);
    add_tick(1000, 20000, 50000);
    add_tick(1000, -20000, 50000);
    add_tick(1000, -32768, 50000);
    add_tick(1000, 32767, 50000);
    add_tick(500, 100, 0);
    add_tick(500, 100, 500000);
    add_tick(500, 100, 500001);
    add_tick(500, 100, 1048575);
    add_tick(0, 16384, 100000);
    add_tick(-1, 1, 1);
    add_tick(32767, 0, 500000);
    add_tick(-32768, 5000, 500000);
    add_random(50);
    drain();

    write_reg(REG_INV_WHEELBASE, 65535);
    write_reg(REG_MAX_STEP_US, 1048575);
    hold_len = 3000;
    no_idle = 1'b1;
    for (int i = 0; i < 70; i++) add_tick(32767, 0, 1048575);
    for (int i = 0; i < 10; i++) add_tick(-32768, 16384, 1048575);
    drain();
    no_idle = 1'b0;
    add_random(30);
    drain();

    write_reg(REG_INV_WHEELBASE, 1);
    write_reg(REG_MAX_STEP_US, 1);
    add_random(30);
    drain();

    write_reg(REG_MAX_STEP_US, 0);
    add_random(8);
    drain();
    write_reg(REG_INV_WHEELBASE, 0);
    write_reg(REG_MAX_STEP_US, 1000);
    add_random(20);
    drain();

    write_reg(REG_INV_WHEELBASE, 15938);
    write_reg(REG_MAX_STEP_US, 500000);
    add_random(120);
    drain();

    write_reg(REG_INV_WHEELBASE, $urandom_range(65535, 1));
    write_reg(REG_MAX_STEP_US, $urandom_range(1048575, 1));
    add_random(80);
    drain();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("bicycle_model_dead_reckoning test passed");
    end else begin
      $display("bicycle_model_dead_reckoning test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/bmdr_pkg.sv
rtl/core/bmdr_mul.sv
rtl/core/bmdr_div.sv
rtl/core/bmdr_cordic.sv
rtl/core/bicycle_model_dead_reckoning.sv
rtl/core/bmdr_checker.sv
sim/testbench.sv
